// ===== src/tlbp_pkg.sv =====
// Package for the two-level branch predictor: constants, codes and shared types.
// Used by the interfaces, the counter/entry store and the top level.
package tlbp_pkg;

  localparam int unsigned MAX_ENTRIES_DEFAULT = 32;
  localparam int unsigned MAX_HISTORY_DEFAULT = 8;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 30;
  localparam int unsigned TAG_MAX    = 30;
  localparam int unsigned CTR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned SHARE_SHIFT_LOW  = 2;
  localparam int unsigned SHARE_SHIFT_HIGH = 16;
  localparam logic [ADDR_W-1:0] PC_STEP = 32'd4;

  typedef enum logic {
    OP_PREDICT = 1'b0,
    OP_UPDATE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SHARE_NONE = 2'd0,
    SHARE_LOW  = 2'd1,
    SHARE_HIGH = 2'd2
  } share_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INDEX_BITS     = 3'd0,
    CFG_TAG_BITS       = 3'd1,
    CFG_HISTORY_BITS   = 3'd2,
    CFG_COUNTER_INIT   = 3'd3,
    CFG_GLOBAL_HISTORY = 3'd4,
    CFG_GLOBAL_CTRS    = 3'd5,
    CFG_SHARE_MODE     = 3'd6
  } cfg_reg_e;

  // Control from the top level to the store.
  typedef struct packed {
    logic rd_en;   // new item accepted: capture read data
    logic ent_we;  // write entry word (tag, target)
    logic row_we;  // write counter row
    logic clear;   // drop all counter rows back to the init value
  } store_ctl_t;

endpackage

// ===== src/tlbp_if.sv =====
// Channel interfaces of the branch predictor: request, result and config write.
// Depends on tlbp_pkg for field widths.
interface tlbp_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [tlbp_pkg::ADDR_W-1:0]   branch_pc;
  logic [tlbp_pkg::ADDR_W-1:0]   resolved_target;
  logic                          resolved_taken;
  logic [tlbp_pkg::ADDR_W-1:0]   earlier_prediction;

  modport source (output valid, op, branch_pc, resolved_target, resolved_taken,
                  earlier_prediction, input ready);
  modport sink   (input valid, op, branch_pc, resolved_target, resolved_taken,
                  earlier_prediction, output ready);
endinterface

interface tlbp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          predict_taken;
  logic [tlbp_pkg::ADDR_W-1:0]   next_address;
  logic                          was_flush;
  logic [tlbp_pkg::ADDR_W-1:0]   branches_seen;
  logic [tlbp_pkg::ADDR_W-1:0]   flushes_seen;

  modport source (output valid, predict_taken, next_address, was_flush, branches_seen,
                  flushes_seen, input ready);
  modport sink   (input valid, predict_taken, next_address, was_flush, branches_seen,
                  flushes_seen, output ready);
endinterface

interface tlbp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tlbp_pkg::CFG_IDX_W-1:0]   index;
  logic [tlbp_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tlbp_store.sv =====
// Entry RAM (tag, target) and counter-row RAM with registered reads and write bypass.
// Depends on tlbp_pkg (store_ctl_t, widths).
module tlbp_store #(
  parameter int unsigned NUM_ENTRIES = tlbp_pkg::MAX_ENTRIES_DEFAULT,
  parameter int unsigned HIST_BITS   = tlbp_pkg::MAX_HISTORY_DEFAULT,
  localparam int unsigned IW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int unsigned RW    = $clog2(NUM_ENTRIES + 1),
  localparam int unsigned ROW_W = tlbp_pkg::CTR_W << HIST_BITS,
  localparam int unsigned EW    = tlbp_pkg::TAG_W + tlbp_pkg::ADDR_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tlbp_pkg::store_ctl_t ctl_i,
  input  logic [IW-1:0]        ent_raddr_i,
  input  logic [IW-1:0]        ent_waddr_i,
  input  logic [EW-1:0]        ent_wdata_i,
  input  logic [RW-1:0]        row_raddr_i,
  input  logic [RW-1:0]        row_waddr_i,
  input  logic [ROW_W-1:0]     row_wdata_i,
  input  logic [ROW_W-1:0]     row_init_i,
  output logic [EW-1:0]        ent_rdata_o,
  output logic [ROW_W-1:0]     row_rdata_o
);

  // rows 0..NUM_ENTRIES-1 are local counter rows, row NUM_ENTRIES is the shared table
  localparam int unsigned ROWS = NUM_ENTRIES + 1;

  logic [EW-1:0]    ent_mem [NUM_ENTRIES];
  logic [ROW_W-1:0] row_mem [ROWS];
  logic [ROWS-1:0]  row_vld_q;

  logic [EW-1:0]    ent_rd_q, ent_byp_data_q;
  logic             ent_byp_q;
  logic [ROW_W-1:0] row_rd_q, row_byp_data_q;
  logic             row_byp_q, row_vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_we) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    if (ctl_i.row_we) begin
      row_mem[row_waddr_i] <= row_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      ent_rd_q       <= ent_mem[ent_raddr_i];
      ent_byp_data_q <= ent_wdata_i;
      row_rd_q       <= row_mem[row_raddr_i];
      row_byp_data_q <= row_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q    <= '0;
      ent_byp_q    <= 1'b0;
      row_byp_q    <= 1'b0;
      row_vld_rd_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        row_vld_q <= '0;
      end else if (ctl_i.row_we) begin
        row_vld_q[row_waddr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        // same-edge write to the row being read: take the new data
        ent_byp_q    <= ctl_i.ent_we && (ent_waddr_i == ent_raddr_i);
        row_byp_q    <= ctl_i.row_we && (row_waddr_i == row_raddr_i);
        row_vld_rd_q <= row_vld_q[row_raddr_i];
      end
    end
  end

  assign ent_rdata_o = ent_byp_q ? ent_byp_data_q : ent_rd_q;
  assign row_rdata_o = row_byp_q    ? row_byp_data_q :
                       row_vld_rd_q ? row_rd_q       : row_init_i;

endmodule

// ===== src/two_level_branch_predictor.sv =====
// Two-level branch predictor with direct-mapped BTB; an item passes the accept and
// result registers. Throughput: 1 item per cycle unless the result is stalled, set
// by the single counter-row RAM read issued at accept and written back as the item
// leaves the accept register (bypassed). Reset and config writes to listed registers
// clear entry/row valid bits, histories and both counters; no clearing pass, ready.
module two_level_branch_predictor #(
  parameter int unsigned MAX_ENTRIES = tlbp_pkg::MAX_ENTRIES_DEFAULT,
  parameter int unsigned MAX_HISTORY = tlbp_pkg::MAX_HISTORY_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlbp_req_if.sink   req_i,
  tlbp_rsp_if.source rsp_o,
  tlbp_cfg_if.sink   cfg_i
);

  localparam int unsigned IW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned RW       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LOG_ENT  = $clog2(MAX_ENTRIES + 1) - 1; // floor(log2)
  localparam int unsigned HW       = MAX_HISTORY;
  localparam int unsigned ROW_LEN  = 1 << MAX_HISTORY;
  localparam int unsigned ROW_W    = tlbp_pkg::CTR_W * ROW_LEN;
  localparam int unsigned TW       = tlbp_pkg::TAG_W;
  localparam int unsigned AW       = tlbp_pkg::ADDR_W;
  localparam int unsigned EW       = TW + AW;
  localparam logic [RW-1:0] SHARED_ROW = RW'(MAX_ENTRIES);

  // ---------------------------------------------------------------------------
  // Configuration registers; a write to a listed register re-initializes the predictor state.
  // ---------------------------------------------------------------------------
  logic [2:0] index_bits_q;
  logic [4:0] tag_bits_q;
  logic [3:0] history_bits_q;
  logic [1:0] counter_init_q;
  logic       global_history_q, global_counters_q;
  logic [1:0] share_mode_q;
  logic       cfg_acc, reinit;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  // only listed registers re-init; a write past the list is dropped
  assign reinit = cfg_acc && (cfg_i.index <= tlbp_pkg::CFG_SHARE_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q      <= 3'd0;
      tag_bits_q        <= 5'd0;
      history_bits_q    <= 4'd1;
      counter_init_q    <= 2'd1;
      global_history_q  <= 1'b0;
      global_counters_q <= 1'b0;
      share_mode_q      <= tlbp_pkg::SHARE_NONE;
    end else if (cfg_acc) begin
      unique case (tlbp_pkg::cfg_reg_e'(cfg_i.index))
        tlbp_pkg::CFG_INDEX_BITS:     index_bits_q      <= cfg_i.data[2:0];
        tlbp_pkg::CFG_TAG_BITS:       tag_bits_q        <= cfg_i.data[4:0];
        tlbp_pkg::CFG_HISTORY_BITS:   history_bits_q    <= cfg_i.data[3:0];
        tlbp_pkg::CFG_COUNTER_INIT:   counter_init_q    <= cfg_i.data[1:0];
        tlbp_pkg::CFG_GLOBAL_HISTORY: global_history_q  <= cfg_i.data[0];
        tlbp_pkg::CFG_GLOBAL_CTRS:    global_counters_q <= cfg_i.data[0];
        tlbp_pkg::CFG_SHARE_MODE:     share_mode_q      <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) settings
  logic [2:0]    ib;
  logic [4:0]    tb;
  logic [3:0]    hb;
  logic [IW-1:0] imask;
  logic [TW-1:0] tmask;
  logic [HW-1:0] hmask;
  logic          gh, gc;

  assign gh = global_history_q;
  assign gc = global_counters_q;

  always_comb begin
    ib = (int'(index_bits_q) > int'(LOG_ENT)) ? 3'(LOG_ENT) : index_bits_q;
    tb = (int'(tag_bits_q) > int'(tlbp_pkg::TAG_MAX)) ? 5'(tlbp_pkg::TAG_MAX) : tag_bits_q;
    if (history_bits_q == 4'd0) begin
      hb = 4'd1;
    end else if (int'(history_bits_q) > int'(MAX_HISTORY)) begin
      hb = 4'(MAX_HISTORY);
    end else begin
      hb = history_bits_q;
    end
    for (int i = 0; i < IW; i++) imask[i] = (i < int'(ib));
    for (int i = 0; i < TW; i++) tmask[i] = (i < int'(tb));
    for (int i = 0; i < HW; i++) hmask[i] = (i < int'(hb));
  end

  // ---------------------------------------------------------------------------
  // Accept stage: issue the RAM reads from the incoming pc
  // ---------------------------------------------------------------------------
  logic          s1_valid_q, s1_adv, req_acc;
  logic          s1_op_q, s1_taken_q;
  logic [AW-1:0] s1_pc_q, s1_tgt_q, s1_pred_q;
  logic [IW-1:0] in_idx;
  logic [RW-1:0] in_row;
  logic          out_valid_q;

  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  assign in_idx = req_i.branch_pc[2 +: IW] & imask;
  assign in_row = gc ? SHARED_ROW : RW'(in_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_op_q    <= req_i.op;
      s1_pc_q    <= req_i.branch_pc;
      s1_tgt_q   <= req_i.resolved_target;
      s1_taken_q <= req_i.resolved_taken;
      s1_pred_q  <= req_i.earlier_prediction;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup / train stage
  // ---------------------------------------------------------------------------
  logic [MAX_ENTRIES-1:0] entry_valid_q;
  logic [HW-1:0]          local_hist_q [MAX_ENTRIES];
  logic [HW-1:0]          shared_hist_q;
  logic [AW-1:0]          update_cnt_q, flush_cnt_q;

  logic [IW-1:0]    idx;
  logic [RW-1:0]    row_addr;
  logic [TW-1:0]    tag;
  logic [EW-1:0]    ent_rdata;
  logic [ROW_W-1:0] row_rdata, row_init, row_cur, row_new;
  logic             hit, both_global, reset_local, is_update;
  logic [HW-1:0]    hist, share_bits, slot, col, hist_new;
  logic [1:0]       ctr, ctr_new;
  logic [AW-1:0]    pc4;
  logic             flush, pred_taken;
  logic [AW-1:0]    next_addr;

  assign row_init = {ROW_LEN{counter_init_q}};
  assign is_update = (s1_op_q == tlbp_pkg::OP_UPDATE);

  always_comb begin
    idx         = s1_pc_q[2 +: IW] & imask;
    row_addr    = gc ? SHARED_ROW : RW'(idx);
    tag         = (s1_pc_q[AW-1:2] >> ib) & tmask;
    hit         = entry_valid_q[idx] && (ent_rdata[EW-1 -: TW] == tag);
    both_global = gh && gc;
    // a miss reallocates the entry and restarts its local state
    reset_local = !hit && !both_global;

    if (reset_local && !gh) begin
      hist = '0;
    end else begin
      hist = (gh ? shared_hist_q : local_hist_q[idx]) & hmask;
    end
    row_cur = (reset_local && !gc) ? row_init : row_rdata;

    unique case (share_mode_q)
      tlbp_pkg::SHARE_LOW:  share_bits = s1_pc_q[tlbp_pkg::SHARE_SHIFT_LOW +: HW];
      tlbp_pkg::SHARE_HIGH: share_bits = s1_pc_q[tlbp_pkg::SHARE_SHIFT_HIGH +: HW];
      default:              share_bits = '0;
    endcase
    slot = (hist ^ share_bits) & hmask;
    col  = gc ? slot : hist;
    ctr  = row_cur[{col, 1'b0} +: 2];

    // two-bit saturating counter
    if (s1_taken_q) begin
      ctr_new = (ctr == 2'd3) ? ctr : ctr + 2'd1;
    end else begin
      ctr_new = (ctr == 2'd0) ? ctr : ctr - 2'd1;
    end
    row_new = row_cur;
    row_new[{col, 1'b0} +: 2] = ctr_new;

    hist_new = ((hist << 1) | HW'(s1_taken_q)) & hmask;

    pc4   = s1_pc_q + tlbp_pkg::PC_STEP;
    flush = s1_taken_q ? (s1_pred_q != s1_tgt_q) : (s1_pred_q != pc4);

    pred_taken = hit && ctr[1];
    next_addr  = pred_taken ? ent_rdata[AW-1:0] : pc4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      shared_hist_q <= '0;
      update_cnt_q  <= '0;
      flush_cnt_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) local_hist_q[i] <= '0;
    end else if (reinit) begin
      entry_valid_q <= '0;
      shared_hist_q <= '0;
      update_cnt_q  <= '0;
      flush_cnt_q   <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) local_hist_q[i] <= '0;
    end else if (s1_adv && is_update) begin
      entry_valid_q[idx] <= 1'b1;
      update_cnt_q       <= update_cnt_q + 32'd1;
      flush_cnt_q        <= flush_cnt_q + AW'(flush);
      if (gh) begin
        shared_hist_q <= hist_new;
      end else begin
        local_hist_q[idx] <= hist_new;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Store: entry word {tag, target} and counter rows
  // ---------------------------------------------------------------------------
  tlbp_pkg::store_ctl_t store_ctl;

  always_comb begin
    store_ctl.rd_en  = req_acc;
    store_ctl.ent_we = s1_adv && is_update;
    store_ctl.row_we = s1_adv && is_update;
    store_ctl.clear  = reinit;
  end

  tlbp_store #(
    .NUM_ENTRIES (MAX_ENTRIES),
    .HIST_BITS   (MAX_HISTORY)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (store_ctl),
    .ent_raddr_i (in_idx),
    .ent_waddr_i (idx),
    .ent_wdata_i ({tag, s1_tgt_q}),
    .row_raddr_i (in_row),
    .row_waddr_i (row_addr),
    .row_wdata_i (row_new),
    .row_init_i  (row_init),
    .ent_rdata_o (ent_rdata),
    .row_rdata_o (row_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic          out_taken_q, out_flush_q;
  logic [AW-1:0] out_next_q, out_branches_q, out_flushes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (is_update) begin
        out_taken_q    <= 1'b0;
        out_next_q     <= '0;
        out_flush_q    <= flush;
        out_branches_q <= update_cnt_q + 32'd1;
        out_flushes_q  <= flush_cnt_q + AW'(flush);
      end else begin
        out_taken_q    <= pred_taken;
        out_next_q     <= next_addr;
        out_flush_q    <= 1'b0;
        out_branches_q <= update_cnt_q;
        out_flushes_q  <= flush_cnt_q;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.predict_taken = out_taken_q;
  assign rsp_o.next_address  = out_next_q;
  assign rsp_o.was_flush     = out_flush_q;
  assign rsp_o.branches_seen = out_branches_q;
  assign rsp_o.flushes_seen  = out_flushes_q;

endmodule
